FILE: hw/rtl/tpm_pkg.sv
// Package for the thermal persistence monitor: lane and run indices, register map,
// shared result types and the Q10 fixed-point widths.
// No dependencies; compiled first.
package tpm_pkg;

  localparam int RUN_WIDTH  = 8;
  localparam int LONG_RUN   = 12;
  localparam int SKIN_RUN   = 6;

  localparam int SAMPLE_W   = 10;
  localparam int GAIN_W     = 10;
  localparam int OFFSET_W   = 8;
  localparam int LIMIT_W    = 10;
  localparam int PERIOD_W   = 16;
  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 12;
  localparam int FRAC_W     = 10;
  localparam int PRODUCT_W  = SAMPLE_W + GAIN_W;
  localparam int SCALED_W   = PRODUCT_W + 2;

  localparam int NUM_LANES  = 4;
  localparam int NUM_RUNS   = 5;

  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // Lane order follows the sensor order of an input beat.
  localparam int LANE_EMITTER = 0;
  localparam int LANE_BOARD   = 1;
  localparam int LANE_SKIN    = 2;
  localparam int LANE_AIR     = 3;

  localparam int RUN_EMITTER  = 0;
  localparam int RUN_BOARD    = 1;
  localparam int RUN_SKIN_HOT = 2;
  localparam int RUN_AIR      = 3;
  localparam int RUN_COLD     = 4;

  typedef enum logic [2:0] {
    REG_GAIN      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_EMITTER   = 3'd2,
    REG_BOARD     = 3'd3,
    REG_SKIN_HOT  = 3'd4,
    REG_AIR       = 3'd5,
    REG_CONTACT   = 3'd6,
    REG_PERIOD    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic                     hot;
    logic                     cold;
    logic signed [TEMP_W-1:0] temp;
  } lane_result_t;

  typedef struct packed {
    logic emitter_hot;
    logic board_hot;
    logic skin_hot;
    logic air_hot;
    logic no_contact;
  } flags_t;

endpackage

FILE: hw/rtl/tpm_if.sv
// Valid/ready channel interfaces for the thermal persistence monitor:
// the sample input channel and the report output channel. Uses tpm_pkg.
interface tpm_in_if;
  import tpm_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [SAMPLE_W-1:0] emitter_sample;
  logic [SAMPLE_W-1:0] board_sample;
  logic [SAMPLE_W-1:0] skin_sample;
  logic [SAMPLE_W-1:0] air_sample;

  modport source (output valid, now_ms, emitter_sample, board_sample, skin_sample,
                  air_sample, input ready);
  modport sink   (input valid, now_ms, emitter_sample, board_sample, skin_sample,
                  air_sample, output ready);
endinterface

interface tpm_out_if;
  import tpm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     sampled;
  logic                     emitter_hot;
  logic                     board_hot;
  logic                     skin_hot;
  logic                     air_hot;
  logic                     no_contact;
  logic signed [TEMP_W-1:0] emitter_temp;
  logic signed [TEMP_W-1:0] board_temp;
  logic signed [TEMP_W-1:0] skin_temp;
  logic signed [TEMP_W-1:0] air_temp;

  modport source (output valid, sampled, emitter_hot, board_hot, skin_hot, air_hot,
                  no_contact, emitter_temp, board_temp, skin_temp, air_temp,
                  input ready);
  modport sink   (input valid, sampled, emitter_hot, board_hot, skin_hot, air_hot,
                  no_contact, emitter_temp, board_temp, skin_temp, air_temp,
                  output ready);
endinterface

FILE: hw/rtl/tpm_lane.sv
// One sensor lane: Q10 conversion of an ADC code, limit compares and flooring.
// Depends on tpm_pkg.
module tpm_lane (
  input  logic [tpm_pkg::SAMPLE_W-1:0]        sample,
  input  logic [tpm_pkg::GAIN_W-1:0]          gain_q10,
  input  logic signed [tpm_pkg::OFFSET_W-1:0] offset_degrees,
  input  logic [tpm_pkg::LIMIT_W-1:0]         hot_limit,
  input  logic [tpm_pkg::LIMIT_W-1:0]         cold_limit,
  output tpm_pkg::lane_result_t               result
);
  import tpm_pkg::*;

  logic [PRODUCT_W-1:0]       product;
  logic signed [SCALED_W-1:0] offset_q10;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SCALED_W-1:0] hot_q10;
  logic signed [SCALED_W-1:0] cold_q10;

  assign product    = PRODUCT_W'(sample) * PRODUCT_W'(gain_q10);
  assign offset_q10 = {{(SCALED_W-OFFSET_W-FRAC_W){offset_degrees[OFFSET_W-1]}},
                       offset_degrees, {FRAC_W{1'b0}}};
  assign scaled     = $signed({2'b00, product}) + offset_q10;

  // Limits are whole degrees, so shifting them up keeps the compare exact.
  assign hot_q10  = $signed({{(SCALED_W-LIMIT_W-FRAC_W){1'b0}}, hot_limit, {FRAC_W{1'b0}}});
  assign cold_q10 = $signed({{(SCALED_W-LIMIT_W-FRAC_W){1'b0}}, cold_limit, {FRAC_W{1'b0}}});

  assign result.hot  = (scaled >= hot_q10);
  assign result.cold = (scaled <= cold_q10);
  // Dropping the fraction bits of a two's complement value floors it.
  assign result.temp = scaled[FRAC_W +: TEMP_W];

endmodule

FILE: hw/rtl/tpm_merge.sv
// Merging stage: run counters and stored temperatures, updated from the four lanes
// on an accepted sample set. Depends on tpm_pkg.
module tpm_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             update,
  input  tpm_pkg::lane_result_t            lane [tpm_pkg::NUM_LANES],
  output tpm_pkg::flags_t                  flags_next,
  output logic signed [tpm_pkg::TEMP_W-1:0] temps_next [tpm_pkg::NUM_LANES]
);
  import tpm_pkg::*;

  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  logic [RUN_WIDTH-1:0]     run      [NUM_RUNS];
  logic [RUN_WIDTH-1:0]     run_next [NUM_RUNS];
  logic [NUM_RUNS-1:0]      cond;
  logic signed [TEMP_W-1:0] temps    [NUM_LANES];

  always_comb begin
    cond[RUN_EMITTER]  = lane[LANE_EMITTER].hot;
    cond[RUN_BOARD]    = lane[LANE_BOARD].hot;
    cond[RUN_SKIN_HOT] = lane[LANE_SKIN].hot;
    cond[RUN_AIR]      = lane[LANE_AIR].hot;
    cond[RUN_COLD]     = lane[LANE_SKIN].cold;
  end

  always_comb begin
    for (int r = 0; r < NUM_RUNS; r++) begin
      if (!update) begin
        run_next[r] = run[r];
      end else if (!cond[r]) begin
        run_next[r] = '0;
      end else if (run[r] == RUN_MAX) begin
        run_next[r] = RUN_MAX;
      end else begin
        run_next[r] = run[r] + 1'b1;
      end
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      temps_next[l] = update ? lane[l].temp : temps[l];
    end
  end

  assign flags_next.emitter_hot = (run_next[RUN_EMITTER]  >= RUN_WIDTH'(LONG_RUN));
  assign flags_next.board_hot   = (run_next[RUN_BOARD]    >= RUN_WIDTH'(LONG_RUN));
  assign flags_next.skin_hot    = (run_next[RUN_SKIN_HOT] >= RUN_WIDTH'(SKIN_RUN));
  assign flags_next.air_hot     = (run_next[RUN_AIR]      >= RUN_WIDTH'(LONG_RUN));
  assign flags_next.no_contact  = (run_next[RUN_COLD]     >= RUN_WIDTH'(LONG_RUN));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_RUNS; r++) run[r] <= '0;
      for (int l = 0; l < NUM_LANES; l++) temps[l] <= '0;
    end else begin
      for (int r = 0; r < NUM_RUNS; r++) run[r] <= run_next[r];
      for (int l = 0; l < NUM_LANES; l++) temps[l] <= temps_next[l];
    end
  end

endmodule

FILE: hw/rtl/thermal_persistence_monitor.sv
// Top level of the thermal persistence monitor: APB register file, sample-period
// gate, four sensor lanes and the merging stage. Depends on tpm_pkg, tpm_if,
// tpm_lane and tpm_merge.
//
// The monitor takes one sample beat per clock while the report channel is not
// stalled, and returns exactly one report beat for each, registered in the cycle
// after it, from an output register. A beat is taken into account only when more
// than period_ms milliseconds (modulo 2^32) have passed since the last set that
// was taken; it then runs through four parallel lanes, each with one 10 by 10 bit
// multiplier, that turn the ADC codes into Q10 temperatures and compare them
// against the limits, and the merging stage advances or clears the five saturating
// run counters and stores the floored temperatures. The lane multiplier, the limit
// compare and the counter update form one combinational path; the input is ready
// whenever the output register is empty or being emptied in the same cycle. The
// report carries the flags and temperatures as they stand after that beat, whether
// or not it was taken into account. Registers are written over APB at byte
// addresses 4*i and read back zero-extended; pready is always high.
module thermal_persistence_monitor (
  input  logic                          clk,
  input  logic                          rst,
  tpm_in_if.sink                        samples,
  tpm_out_if.source                     report,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpm_pkg::ADDR_W-1:0]    paddr,
  input  logic [tpm_pkg::DATA_W-1:0]    pwdata,
  output logic [tpm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import tpm_pkg::*;

  // Configuration registers.
  logic [GAIN_W-1:0]          gain_q10;
  logic signed [OFFSET_W-1:0] offset_degrees;
  logic [LIMIT_W-1:0]         emitter_limit;
  logic [LIMIT_W-1:0]         board_limit;
  logic [LIMIT_W-1:0]         skin_hot_limit;
  logic [LIMIT_W-1:0]         air_limit;
  logic [LIMIT_W-1:0]         contact_limit;
  logic [PERIOD_W-1:0]        period_ms;

  logic     cfg_write;
  reg_idx_t reg_idx;

  logic [TIME_W-1:0]   last_accept_time;
  logic [TIME_W-1:0]   elapsed;
  logic                fire;
  logic                take;
  logic [SAMPLE_W-1:0] lane_sample [NUM_LANES];
  logic [LIMIT_W-1:0]  lane_limit  [NUM_LANES];
  lane_result_t        lane_res    [NUM_LANES];

  flags_t                   flags_next;
  logic signed [TEMP_W-1:0] temps_next [NUM_LANES];

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q10       <= GAIN_W'(266);
      offset_degrees <= '0;
      emitter_limit  <= LIMIT_W'(85);
      board_limit    <= LIMIT_W'(70);
      skin_hot_limit <= LIMIT_W'(43);
      air_limit      <= LIMIT_W'(43);
      contact_limit  <= LIMIT_W'(28);
      period_ms      <= PERIOD_W'(5000);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_GAIN:     gain_q10       <= pwdata[GAIN_W-1:0];
        REG_OFFSET:   offset_degrees <= $signed(pwdata[OFFSET_W-1:0]);
        REG_EMITTER:  emitter_limit  <= pwdata[LIMIT_W-1:0];
        REG_BOARD:    board_limit    <= pwdata[LIMIT_W-1:0];
        REG_SKIN_HOT: skin_hot_limit <= pwdata[LIMIT_W-1:0];
        REG_AIR:      air_limit      <= pwdata[LIMIT_W-1:0];
        REG_CONTACT:  contact_limit  <= pwdata[LIMIT_W-1:0];
        REG_PERIOD:   period_ms      <= pwdata[PERIOD_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN:     prdata = DATA_W'(gain_q10);
      REG_OFFSET:   prdata = DATA_W'($unsigned(offset_degrees));
      REG_EMITTER:  prdata = DATA_W'(emitter_limit);
      REG_BOARD:    prdata = DATA_W'(board_limit);
      REG_SKIN_HOT: prdata = DATA_W'(skin_hot_limit);
      REG_AIR:      prdata = DATA_W'(air_limit);
      REG_CONTACT:  prdata = DATA_W'(contact_limit);
      REG_PERIOD:   prdata = DATA_W'(period_ms);
      default:      prdata = '0;
    endcase
  end

  // The input is free whenever the report register is empty or empties this cycle.
  assign samples.ready = !report.valid || report.ready;
  assign fire          = samples.valid && samples.ready;

  // Unsigned subtraction gives the elapsed time across a wrap of the clock.
  assign elapsed = samples.now_ms - last_accept_time;
  assign take    = fire && (elapsed > TIME_W'(period_ms));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_accept_time <= '0;
    end else if (take) begin
      last_accept_time <= samples.now_ms;
    end
  end

  always_comb begin
    lane_sample[LANE_EMITTER] = samples.emitter_sample;
    lane_sample[LANE_BOARD]   = samples.board_sample;
    lane_sample[LANE_SKIN]    = samples.skin_sample;
    lane_sample[LANE_AIR]     = samples.air_sample;
    lane_limit[LANE_EMITTER]  = emitter_limit;
    lane_limit[LANE_BOARD]    = board_limit;
    lane_limit[LANE_SKIN]     = skin_hot_limit;
    lane_limit[LANE_AIR]      = air_limit;
  end

  // Every lane gets the contact limit; only the skin lane's cold result is used.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    tpm_lane u_lane (
      .sample         (lane_sample[l]),
      .gain_q10       (gain_q10),
      .offset_degrees (offset_degrees),
      .hot_limit      (lane_limit[l]),
      .cold_limit     (contact_limit),
      .result         (lane_res[l])
    );
  end

  tpm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .update     (take),
    .lane       (lane_res),
    .flags_next (flags_next),
    .temps_next (temps_next)
  );

  // Report register: loaded on every sample beat handed over, taken into account or not.
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (fire) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      report.sampled      <= take;
      report.emitter_hot  <= flags_next.emitter_hot;
      report.board_hot    <= flags_next.board_hot;
      report.skin_hot     <= flags_next.skin_hot;
      report.air_hot      <= flags_next.air_hot;
      report.no_contact   <= flags_next.no_contact;
      report.emitter_temp <= temps_next[LANE_EMITTER];
      report.board_temp   <= temps_next[LANE_BOARD];
      report.skin_temp    <= temps_next[LANE_SKIN];
      report.air_temp     <= temps_next[LANE_AIR];
    end
  end

endmodule

FILE: hw/rtl/tpm_checker.sv
// Port-level checks for the thermal persistence monitor, bound to its top level.
// Depends on tpm_if for the channel members it watches.
module tpm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_sampled,
  input logic pready
);

  // A sample beat always leaves a report waiting in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("sample beat produced no report");

  // An empty report register never holds off the input.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty report register");

  // Without a new sample beat a taken report is not followed by another.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(in_valid && in_ready)) |=> !out_valid)
    else $error("report repeated without a sample beat");

  // A stalled report stays valid and keeps its sampled flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sampled)))
    else $error("stalled report changed");

  assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind thermal_persistence_monitor tpm_checker u_tpm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .out_sampled (report.sampled),
  .pready      (pready)
);

FILE: bench/tb_thermal_persistence_monitor.sv
// Self-checking bench for thermal_persistence_monitor: drives sample beats and APB
// register writes, predicts every report beat and compares it with the block.
// Depends on tpm_pkg, tpm_if and the monitor RTL.
module tb_thermal_persistence_monitor;
  import tpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_ERRORS   = 10;

  // Register that sets the hot threshold of each lane, and the run it feeds.
  localparam reg_idx_t HOT_REG [NUM_LANES] = '{REG_EMITTER, REG_BOARD, REG_SKIN_HOT, REG_AIR};
  localparam int       HOT_RUN [NUM_LANES] = '{RUN_EMITTER, RUN_BOARD, RUN_SKIN_HOT, RUN_AIR};

  typedef struct packed {
    logic [TIME_W-1:0]                   now_ms;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] code;
  } sample_set_t;

  typedef struct packed {
    logic                              sampled;
    flags_t                            flags;
    logic [NUM_LANES-1:0][TEMP_W-1:0] temp;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  // Everything the bench drives starts at a known value.
  logic              in_valid  = 1'b0;
  sample_set_t       in_set    = '0;
  logic              out_ready = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tpm_in_if  samples_if ();
  tpm_out_if report_if ();

  assign samples_if.valid          = in_valid;
  assign samples_if.now_ms         = in_set.now_ms;
  assign samples_if.emitter_sample = in_set.code[LANE_EMITTER];
  assign samples_if.board_sample   = in_set.code[LANE_BOARD];
  assign samples_if.skin_sample    = in_set.code[LANE_SKIN];
  assign samples_if.air_sample     = in_set.code[LANE_AIR];
  assign report_if.ready           = out_ready;

  thermal_persistence_monitor dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .report  (report_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file and of the monitor state, as the predictor sees it.
  logic [15:0]          cfg_reg [8];
  logic [TIME_W-1:0]    last_taken_ms = '0;
  logic [RUN_WIDTH-1:0] run_len [NUM_RUNS];
  logic [TEMP_W-1:0]    stored_temp [NUM_LANES];

  sample_set_t sample_backlog [$];
  report_t     awaited_reports [$];

  int unsigned sets_queued  = 0;
  int unsigned sets_taken   = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_odds    = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  bit          set_taken    = 1'b0;
  logic [TIME_W-1:0] timeline = '0;
  report_t     seen_report;
  report_t     due_report;

  function automatic longint cfg_offset();
    return longint'($signed(cfg_reg[REG_OFFSET][OFFSET_W-1:0]));
  endfunction

  // Works out the report for one sample beat and moves the shadow state on. A beat
  // is taken only when strictly more than the period has elapsed, modulo 2^32.
  function automatic report_t predict_report(sample_set_t s);
    report_t             r;
    longint              scaled;
    logic [NUM_RUNS-1:0] holds;
    logic [TIME_W-1:0]   elapsed;
    elapsed   = s.now_ms - last_taken_ms;
    r.sampled = elapsed > TIME_W'(cfg_reg[REG_PERIOD]);
    if (r.sampled) begin
      holds = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        scaled = longint'(s.code[l]) * longint'(cfg_reg[REG_GAIN]) + cfg_offset() * 1024;
        holds[HOT_RUN[l]] = scaled >= longint'(cfg_reg[HOT_REG[l]]) * 1024;
        if (l == LANE_SKIN)
          holds[RUN_COLD] = scaled <= longint'(cfg_reg[REG_CONTACT]) * 1024;
        // The arithmetic shift floors, negative temperatures included.
        stored_temp[l] = TEMP_W'(scaled >>> FRAC_W);
      end
      for (int k = 0; k < NUM_RUNS; k++) begin
        if (!holds[k])
          run_len[k] = '0;
        else if (run_len[k] != '1)
          run_len[k] = run_len[k] + 1'b1;
      end
      last_taken_ms = s.now_ms;
    end
    r.flags.emitter_hot = run_len[RUN_EMITTER]  >= LONG_RUN;
    r.flags.board_hot   = run_len[RUN_BOARD]    >= LONG_RUN;
    r.flags.skin_hot    = run_len[RUN_SKIN_HOT] >= SKIN_RUN;
    r.flags.air_hot     = run_len[RUN_AIR]      >= LONG_RUN;
    r.flags.no_contact  = run_len[RUN_COLD]     >= LONG_RUN;
    for (int l = 0; l < NUM_LANES; l++)
      r.temp[l] = stored_temp[l];
    return r;
  endfunction

  function automatic string describe(report_t r);
    return $sformatf("sampled=%b flags=%b temps=%0d/%0d/%0d/%0d", r.sampled, r.flags,
                     $signed(r.temp[LANE_EMITTER]), $signed(r.temp[LANE_BOARD]),
                     $signed(r.temp[LANE_SKIN]), $signed(r.temp[LANE_AIR]));
  endfunction

  // Lowest ADC code whose temperature reaches the given limit; 1024 when none does.
  function automatic int code_at_least(logic [15:0] limit);
    longint need;
    longint gain;
    longint c;
    gain = longint'(cfg_reg[REG_GAIN]);
    need = (longint'(limit) - cfg_offset()) * 1024;
    if (need <= 0)
      return 0;
    if (gain == 0)
      return 1024;
    c = (need + gain - 1) / gain;
    return (c > 1024) ? 1024 : int'(c);
  endfunction

  // Highest ADC code whose temperature stays at or below the limit; -1 when none does.
  function automatic int code_at_most(logic [15:0] limit);
    longint need;
    longint gain;
    longint c;
    gain = longint'(cfg_reg[REG_GAIN]);
    need = (longint'(limit) - cfg_offset()) * 1024;
    if (need < 0)
      return -1;
    if (gain == 0)
      return 1023;
    c = need / gain;
    return (c > 1023) ? 1023 : int'(c);
  endfunction

  // Picks a code for one lane under the current settings. Mode 0 aims at or above
  // the hot threshold, mode 1 below it (for the skin, into the no-contact band), mode
  // 3 sits on the threshold itself (for the skin, on the contact limit), and mode 2
  // is plain noise. Where the settings make the aim impossible the code is random.
  function automatic logic [SAMPLE_W-1:0] make_code(int lane, int mode);
    int bound;
    if (lane == LANE_SKIN && mode != 0)
      bound = code_at_most(cfg_reg[REG_CONTACT]) + 1;
    else
      bound = code_at_least(cfg_reg[HOT_REG[lane]]);
    case (mode)
      0: begin
        if (bound <= 1023)
          return ($urandom_range(0, 3) == 0) ? SAMPLE_W'(bound)
                                             : SAMPLE_W'($urandom_range(bound, 1023));
      end
      1: begin
        if (bound >= 1)
          return ($urandom_range(0, 3) == 0) ? SAMPLE_W'(bound - 1)
                                             : SAMPLE_W'($urandom_range(0, bound - 1));
      end
      3: begin
        if (bound >= 1 && bound <= 1023)
          return SAMPLE_W'(bound - int'($urandom_range(0, 1)));
      end
      default: ;
    endcase
    return SAMPLE_W'($urandom);
  endfunction

  task automatic queue_set(logic [TIME_W-1:0] now, logic [SAMPLE_W-1:0] e, b, sk, a);
    sample_set_t s;
    s.now_ms             = now;
    s.code[LANE_EMITTER] = e;
    s.code[LANE_BOARD]   = b;
    s.code[LANE_SKIN]    = sk;
    s.code[LANE_AIR]     = a;
    sample_backlog.push_back(s);
    sets_queued++;
  endtask

  // A stretch of sample sets in which every lane keeps one aim. A steady stretch
  // steps the time by just over one period so that every set is taken; otherwise
  // some sets come too early, and now and then the time jumps or is pushed up to
  // the wrap point.
  task automatic queue_episode(int len, int force_mode, bit steady);
    int                  mode [NUM_LANES];
    int unsigned         period;
    logic [SAMPLE_W-1:0] c [NUM_LANES];
    period = cfg_reg[REG_PERIOD];
    foreach (mode[l])
      mode[l] = (force_mode >= 0) ? force_mode : int'($urandom_range(0, 3));
    repeat (len) begin
      if (steady) begin
        timeline += period + 1;
      end else begin
        case ($urandom_range(0, 19))
          0:       timeline = $urandom;
          1:       timeline = 32'hFFFF_FFFF - $urandom_range(0, period);
          2, 3:    timeline += $urandom_range(0, period);
          default: timeline += period + 1 + $urandom_range(0, 3);
        endcase
      end
      foreach (c[l])
        c[l] = (!steady && $urandom_range(0, 15) == 0) ? SAMPLE_W'($urandom)
                                                       : make_code(l, mode[l]);
      queue_set(timeline, c[LANE_EMITTER], c[LANE_BOARD], c[LANE_SKIN], c[LANE_AIR]);
    end
  endtask

  // APB write: a setup cycle, then an access cycle that completes when pready is seen.
  task automatic write_reg(reg_idx_t idx, int unsigned value);
    int          w;
    logic [15:0] v;
    case (idx)
      REG_GAIN:   w = GAIN_W;
      REG_OFFSET: w = OFFSET_W;
      REG_PERIOD: w = PERIOD_W;
      default:    w = LIMIT_W;
    endcase
    v = 16'(value & ((32'd1 << w) - 1));
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_reg[idx] = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_random_config();
    for (int i = REG_GAIN; i <= REG_PERIOD; i++)
      write_reg(reg_idx_t'(i), $urandom);
  endtask

  // Waits until every queued set has gone in and every report has come back. Each
  // report is registered the cycle after its set, so a short pause idles the block.
  task automatic settle();
    do @(negedge clk); while (sets_taken != sets_queued || awaited_reports.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned count, int unsigned odds);
    int unsigned goal;
    idle_odds = odds;
    goal      = sets_queued + count;
    while (sets_queued < goal)
      queue_episode($urandom_range(1, 30), -1, 1'b0);
    settle();
  endtask

  // Sample driver: a beat is held until it has been taken, and between beats the
  // source sometimes pauses.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !set_taken) begin
      in_valid <= 1'b1;
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (sample_backlog.size() != 0 && idle_odds != 0 &&
                 $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(0, 2);
    end else if (sample_backlog.size() != 0) begin
      in_valid <= 1'b1;
      in_set   <= sample_backlog.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Report sink: ready is dropped now and then, in bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: checks each report beat against the oldest prediction, then predicts
  // the report of any sample beat taken at this edge. The watchdog counts edges at
  // which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (report_if.valid && report_if.ready) begin
        seen_report.sampled           = report_if.sampled;
        seen_report.flags.emitter_hot = report_if.emitter_hot;
        seen_report.flags.board_hot   = report_if.board_hot;
        seen_report.flags.skin_hot    = report_if.skin_hot;
        seen_report.flags.air_hot     = report_if.air_hot;
        seen_report.flags.no_contact  = report_if.no_contact;
        seen_report.temp[LANE_EMITTER] = report_if.emitter_temp;
        seen_report.temp[LANE_BOARD]   = report_if.board_temp;
        seen_report.temp[LANE_SKIN]    = report_if.skin_temp;
        seen_report.temp[LANE_AIR]     = report_if.air_temp;
        if (awaited_reports.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("report beat with none awaited: %s", describe(seen_report));
        end else begin
          due_report = awaited_reports.pop_front();
          if (seen_report !== due_report) begin
            errors++;
            if (errors <= SHOWN_ERRORS)
              $display("report mismatch: expected %s, got %s",
                       describe(due_report), describe(seen_report));
          end
        end
      end
      set_taken = samples_if.valid && samples_if.ready;
      if (set_taken) begin
        sets_taken++;
        awaited_reports.push_back(predict_report(in_set));
      end
      if (set_taken || (report_if.valid && report_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_thermal_persistence_monitor: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int hot_bound [NUM_LANES];
    int cold_top;

    cfg_reg[REG_GAIN]     = 266;
    cfg_reg[REG_OFFSET]   = 0;
    cfg_reg[REG_EMITTER]  = 85;
    cfg_reg[REG_BOARD]    = 70;
    cfg_reg[REG_SKIN_HOT] = 43;
    cfg_reg[REG_AIR]      = 43;
    cfg_reg[REG_CONTACT]  = 28;
    cfg_reg[REG_PERIOD]   = 5000;
    foreach (run_len[k])
      run_len[k] = '0;
    foreach (stored_temp[l])
      stored_temp[l] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings. Straight after reset the last taken
    // time is zero, so a set at time zero and one exactly a period later are both
    // turned away, and the report still carries the zero temperatures.
    idle_odds = 4;
    foreach (hot_bound[l])
      hot_bound[l] = code_at_least(cfg_reg[HOT_REG[l]]);
    cold_top = code_at_most(cfg_reg[REG_CONTACT]);
    queue_set(32'd0, '0, '0, '0, '0);
    queue_set(32'd5000, '1, '1, '1, '1);
    queue_set(32'd5001, '0, '0, '0, '0);
    queue_set(32'd10002, '1, '1, '1, '1);
    // Every lane exactly on its hot threshold, then one code below it.
    timeline = 32'd15003;
    queue_set(timeline, SAMPLE_W'(hot_bound[LANE_EMITTER]), SAMPLE_W'(hot_bound[LANE_BOARD]),
              SAMPLE_W'(hot_bound[LANE_SKIN]), SAMPLE_W'(hot_bound[LANE_AIR]));
    timeline += 5001;
    queue_set(timeline, SAMPLE_W'(hot_bound[LANE_EMITTER] - 1),
              SAMPLE_W'(hot_bound[LANE_BOARD] - 1), SAMPLE_W'(hot_bound[LANE_SKIN] - 1),
              SAMPLE_W'(hot_bound[LANE_AIR] - 1));
    // Skin exactly on the contact limit, then just above it.
    timeline += 5001;
    queue_set(timeline, '0, '0, SAMPLE_W'(cold_top), '0);
    timeline += 5001;
    queue_set(timeline, '0, '0, SAMPLE_W'(cold_top + 1), '0);
    // Elapsed time across the wrap of the millisecond counter: a set just before it,
    // then one too early, then one just over one period later.
    queue_set(32'hFFFF_FFFF, 10'h155, 10'h2AA, 10'h155, 10'h2AA);
    queue_set(32'h0000_1000, 10'h2AA, 10'h155, 10'h2AA, 10'h155);
    queue_set(32'h0000_1388, 10'h2AA, 10'h155, 10'h2AA, 10'h155);
    // A run of hot sets long enough to raise every hot flag.
    timeline = 32'h0000_1388;
    queue_episode(12, 0, 1'b1);
    settle();

    // All registers rewritten with their reset values; long steady runs push the
    // hot counters and then the no-contact counter into saturation.
    idle_odds = 5;
    write_reg(REG_GAIN, 266);
    write_reg(REG_OFFSET, 0);
    write_reg(REG_EMITTER, 85);
    write_reg(REG_BOARD, 70);
    write_reg(REG_SKIN_HOT, 43);
    write_reg(REG_AIR, 43);
    write_reg(REG_CONTACT, 28);
    write_reg(REG_PERIOD, 5000);
    queue_episode(260, 0, 1'b1);
    queue_episode(260, 1, 1'b1);
    run_phase(100, 5);

    // Largest gain and offset with no period at all, and no idling on either side.
    write_reg(REG_GAIN, 1023);
    write_reg(REG_OFFSET, 127);
    write_reg(REG_EMITTER, $urandom_range(0, 1023));
    write_reg(REG_BOARD, $urandom_range(0, 1023));
    write_reg(REG_SKIN_HOT, $urandom_range(0, 1023));
    write_reg(REG_AIR, $urandom_range(0, 1023));
    write_reg(REG_CONTACT, $urandom_range(0, 1023));
    write_reg(REG_PERIOD, 0);
    run_phase(180, 0);

    // Zero gain and the most negative offset: every temperature pinned at the floor,
    // against limits at both ends and the longest period.
    write_reg(REG_GAIN, 0);
    write_reg(REG_OFFSET, -128);
    write_reg(REG_EMITTER, 0);
    write_reg(REG_BOARD, 1023);
    write_reg(REG_SKIN_HOT, 0);
    write_reg(REG_AIR, 1023);
    write_reg(REG_CONTACT, 1023);
    write_reg(REG_PERIOD, 16'hFFFF);
    run_phase(150, 3);

    // Unit gain with a negative offset, so that fractional negative temperatures
    // must be floored.
    write_reg(REG_GAIN, 1);
    write_reg(REG_OFFSET, -128);
    write_reg(REG_EMITTER, $urandom_range(0, 3));
    write_reg(REG_BOARD, $urandom_range(0, 3));
    write_reg(REG_SKIN_HOT, $urandom_range(0, 3));
    write_reg(REG_AIR, $urandom_range(0, 3));
    write_reg(REG_CONTACT, $urandom_range(0, 3));
    write_reg(REG_PERIOD, $urandom_range(0, 100));
    run_phase(150, 6);

    write_random_config();
    run_phase(150, 4);

    // The closing stretch runs without idling on either side.
    write_random_config();
    run_phase(120, 0);

    repeat (4) @(negedge clk);
    if (errors == 0)
      $display("tb_thermal_persistence_monitor: done, clean");
    else
      $display("tb_thermal_persistence_monitor: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tpm_pkg.sv
hw/rtl/tpm_if.sv
hw/rtl/tpm_lane.sv
hw/rtl/tpm_merge.sv
hw/rtl/thermal_persistence_monitor.sv
hw/rtl/tpm_checker.sv
bench/tb_thermal_persistence_monitor.sv
